### rtl/scwf_pkg.sv
// ----------------------------------------------------------------------------
// scwf_pkg
// shared types, codes and helpers of the substring count word filter
// ----------------------------------------------------------------------------
`default_nettype none

package scwf_pkg;

  localparam int PATTERN_BYTES = 8;
  localparam logic [7:0] COUNT_MAX = 8'hFF;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  typedef enum logic [2:0] {
    MODE_ABSENT    = 3'd0,
    MODE_PRESENT   = 3'd1,
    MODE_EQUAL     = 3'd2,
    MODE_AT_LEAST  = 3'd3,
    MODE_AT_MOST   = 3'd4,
    MODE_NOT_EQUAL = 3'd5,
    MODE_INSIDE    = 3'd6,
    MODE_OUTSIDE   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    CFG_PATTERN_CHARS  = 3'd0,
    CFG_PATTERN_LENGTH = 3'd1,
    CFG_MATCH_MODE     = 3'd2,
    CFG_COUNT_LOW      = 3'd3,
    CFG_COUNT_HIGH     = 3'd4,
    CFG_CASE_SENSITIVE = 3'd5,
    CFG_DELIMITER_CHAR = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [63:0] pattern_chars;
    logic [3:0]  pattern_length;
    mode_t       match_mode;
    logic [7:0]  count_low;
    logic [7:0]  count_high;
    logic        case_sensitive;
    logic [7:0]  delimiter_char;
  } cfg_t;

  // one byte stepping through the word window
  typedef struct packed {
    logic       go;
    logic       delim;
    logic [7:0] ch;
  } step_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
    logic [7:0] r;
    r = c;
    if (!cs && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/substring_count_word_filter.sv
// ----------------------------------------------------------------------------
// substring_count_word_filter
// counts overlapping pattern hits per delimited word and emits a verdict
// ----------------------------------------------------------------------------
// path: a delimiter byte is held in the stage-1 register, then its result in the output register
// throughput: one byte per cycle unless a waiting result stalls input, set by the combinational window compare
// a waiting result stalls input only when the next delimiter reaches it
// reset: synchronous active-low rst_n clears handshake state, word count and
//   configuration registers to their defaults
`default_nettype none

module substring_count_word_filter #(
  parameter int MAX_PATTERN = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] char_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [0] word_passed, [8:1] match_count, [15:9] zero
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_addr,
  input  wire  [63:0] cfg_wdata
);

  scwf_pkg::cfg_t  cfg_r;
  scwf_pkg::step_t step;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_delim, s1_adv, out_free;
  logic       out_valid_r, out_valid_nxt;
  logic       out_pass_r;
  logic [7:0] out_count_r;
  logic [7:0] occ;
  logic       passed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_chars  <= '0;
      cfg_r.pattern_length <= 4'd1;
      cfg_r.match_mode     <= scwf_pkg::MODE_PRESENT;
      cfg_r.count_low      <= '0;
      cfg_r.count_high     <= '0;
      cfg_r.case_sensitive <= 1'b1;
      cfg_r.delimiter_char <= scwf_pkg::DELIM_RESET;
    end else if (cfg_we) begin
      unique case (scwf_pkg::cfg_idx_t'(cfg_addr))
        scwf_pkg::CFG_PATTERN_CHARS:  cfg_r.pattern_chars  <= cfg_wdata;
        scwf_pkg::CFG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_wdata[3:0];
        scwf_pkg::CFG_MATCH_MODE:     cfg_r.match_mode     <= scwf_pkg::mode_t'(cfg_wdata[2:0]);
        scwf_pkg::CFG_COUNT_LOW:      cfg_r.count_low      <= cfg_wdata[7:0];
        scwf_pkg::CFG_COUNT_HIGH:     cfg_r.count_high     <= cfg_wdata[7:0];
        scwf_pkg::CFG_CASE_SENSITIVE: cfg_r.case_sensitive <= cfg_wdata[0];
        scwf_pkg::CFG_DELIMITER_CHAR: cfg_r.delimiter_char <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign s1_delim  = (s1_char_r == cfg_r.delimiter_char);
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_delim || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  assign step.go    = s1_adv;
  assign step.delim = s1_delim;
  assign step.ch    = s1_char_r;

  scwf_window #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .step  (step),
    .occ   (occ)
  );

  scwf_verdict u_verdict (
    .mode   (cfg_r.match_mode),
    .lo     (cfg_r.count_low),
    .hi     (cfg_r.count_high),
    .count  (occ),
    .passed (passed)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_delim) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r <= in_tdata;
    end
    if (s1_adv && s1_delim) begin
      out_pass_r  <= passed;
      out_count_r <= occ;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_count_r, out_pass_r};

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  a_delim_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_delim && out_valid_r && !out_tready) |=> s1_valid_r)
    else $error("delimiter dropped while result pending");

  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step.go && step.delim) |=> (occ == 8'd0))
    else $error("count not cleared after word end");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (occ == scwf_pkg::COUNT_MAX && step.go && !step.delim) |=>
      (occ == scwf_pkg::COUNT_MAX))
    else $error("count wrapped past saturation");
`endif

endmodule

`default_nettype wire

### rtl/scwf_window.sv
// ----------------------------------------------------------------------------
// scwf_window
// per-word byte window, pattern compare and saturating occurrence count
// ----------------------------------------------------------------------------
`default_nettype none

module scwf_window #(
  parameter int MAX_PATTERN = 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  scwf_pkg::cfg_t   cfg,
  input  scwf_pkg::step_t  step,
  output logic [7:0]       occ
);

  localparam int EFF_MAX = (MAX_PATTERN < scwf_pkg::PATTERN_BYTES) ?
                           MAX_PATTERN : scwf_pkg::PATTERN_BYTES;
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PATTERN);

  logic [7:0]       win_r   [MAX_PATTERN];
  logic [7:0]       win_nxt [MAX_PATTERN];
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_sh;
  logic [7:0]       occ_r, occ_nxt;
  logic [3:0]       eff_len;
  logic [EFF_MAX-1:0] mlen;
  logic             sel_hit, hit;

  // window as it stands after the new byte is shifted in
  always_comb begin
    win_nxt[0] = step.ch;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  assign cnt_sh = (cnt_r == CNT_FULL) ? CNT_FULL : cnt_r + 1'b1;
  assign eff_len = (cfg.pattern_length > 4'(EFF_MAX)) ? 4'(EFF_MAX) : cfg.pattern_length;

  // one comparator row per candidate pattern length
  for (genvar L = 1; L <= EFF_MAX; L++) begin : g_len
    logic [L-1:0] eq;
    for (genvar k = 0; k < L; k++) begin : g_chr
      assign eq[k] =
        scwf_pkg::fold(cfg.pattern_chars[8*k +: 8], cfg.case_sensitive) ==
        scwf_pkg::fold(win_nxt[L-1-k], cfg.case_sensitive);
    end
    assign mlen[L-1] = &eq;
  end

  always_comb begin
    sel_hit = 1'b0;
    for (int L = 1; L <= EFF_MAX; L++) begin
      if (eff_len == 4'(L)) begin
        sel_hit = mlen[L-1];
      end
    end
  end

  assign hit = (eff_len != 4'd0) && (CMP_W'(cnt_sh) >= CMP_W'(eff_len)) && sel_hit;

  always_comb begin
    cnt_nxt = cnt_r;
    occ_nxt = occ_r;
    if (step.go) begin
      if (step.delim) begin
        cnt_nxt = '0;
        occ_nxt = '0;
      end else begin
        cnt_nxt = cnt_sh;
        if (hit && (occ_r != scwf_pkg::COUNT_MAX)) begin
          occ_nxt = occ_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      occ_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.go && !step.delim) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  assign occ = occ_r;

endmodule

`default_nettype wire

### rtl/scwf_verdict.sv
// ----------------------------------------------------------------------------
// scwf_verdict
// count mode check of a finished word
// ----------------------------------------------------------------------------
`default_nettype none

module scwf_verdict (
  input  scwf_pkg::mode_t mode,
  input  wire [7:0]       lo,
  input  wire [7:0]       hi,
  input  wire [7:0]       count,
  output logic            passed
);

  always_comb begin
    unique case (mode)
      scwf_pkg::MODE_ABSENT:    passed = (count == 8'd0);
      scwf_pkg::MODE_PRESENT:   passed = (count != 8'd0);
      scwf_pkg::MODE_EQUAL:     passed = (count == lo);
      scwf_pkg::MODE_AT_LEAST:  passed = (count >= lo);
      scwf_pkg::MODE_AT_MOST:   passed = (count <= lo);
      scwf_pkg::MODE_NOT_EQUAL: passed = (count != lo);
      scwf_pkg::MODE_INSIDE:    passed = (count >= lo) && (count <= hi);
      scwf_pkg::MODE_OUTSIDE:   passed = (count < lo) || (count > hi);
      default:                  passed = 1'b0;
    endcase
  end

endmodule

`default_nettype wire
